/* hw/rtl/gats_pkg.sv */
// Shared types and constants of the small-quantity revenue block.
package gats_pkg;

	localparam int CODE_W        = 8;
	localparam int QTY_W         = 15;
	localparam int PRICE_W       = 31;
	localparam int TOTAL_W       = 63;
	localparam int CFG_IDX_W     = 2;
	localparam int MAX_GROUP_DEF = 64;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BRAND     = 2'd0,
		CFG_CONTAINER = 2'd1
	} cfg_idx_t;

	typedef enum logic {
		MODE_ROW    = 1'b0,
		MODE_FINISH = 1'b1
	} mode_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_WALK = 1'b1
	} state_t;

	// Control from the sequencer to the group unit
	typedef struct packed {
		logic wr;
		logic walk;
	} gats_ctrl_t;

	// Status from the group unit back to the sequencer
	typedef struct packed {
		logic               full;
		logic               done;
		logic               hit;
		logic [PRICE_W-1:0] hit_price;
	} gats_stat_t;

endpackage

/* hw/rtl/gats_walk.sv */
// Group buffer, quantity sum and count, and the pipelined walk that tests each buffered row.
module gats_walk #(
	parameter int MAX_GROUP = gats_pkg::MAX_GROUP_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gats_pkg::gats_ctrl_t         ctrl,
	input  logic [gats_pkg::QTY_W-1:0]   wr_qty,
	input  logic [gats_pkg::PRICE_W-1:0] wr_price,
	output gats_pkg::gats_stat_t         stat
);

	localparam int CNT_W  = $clog2(MAX_GROUP + 1);
	localparam int IDX_W  = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
	localparam int SUM_W  = gats_pkg::QTY_W + CNT_W;
	localparam int QX5_W  = gats_pkg::QTY_W + 3;
	localparam int PROD_W = QX5_W + CNT_W;

	logic [gats_pkg::QTY_W-1:0]   qty_mem   [MAX_GROUP];
	logic [gats_pkg::PRICE_W-1:0] price_mem [MAX_GROUP];

	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] idx_q;

	logic                         v_s1, v_s2, v_s3;
	logic [gats_pkg::QTY_W-1:0]   qty_s1;
	logic [gats_pkg::PRICE_W-1:0] price_s1, price_s2, price_s3;
	logic [PROD_W-1:0]            prod_s2;
	logic                         hit_s3;

	logic             issue;
	logic             done;
	logic [QX5_W-1:0] qty_x5;

	assign issue  = ctrl.walk && (idx_q < count_q);
	assign done   = ctrl.walk && !issue && !v_s1 && !v_s2 && !v_s3;
	// times five as shift and add
	assign qty_x5 = QX5_W'({qty_s1, 2'b00}) + QX5_W'(qty_s1);

	// Buffer write and registered read
	always_ff @(posedge clk) begin
		if (ctrl.wr) begin
			qty_mem[count_q[IDX_W-1:0]]   <= wr_qty;
			price_mem[count_q[IDX_W-1:0]] <= wr_price;
		end
		qty_s1   <= qty_mem[idx_q[IDX_W-1:0]];
		price_s1 <= price_mem[idx_q[IDX_W-1:0]];
	end

	// Walk datapath
	always_ff @(posedge clk) begin
		prod_s2  <= PROD_W'(qty_x5) * PROD_W'(count_q);
		price_s2 <= price_s1;
		hit_s3   <= prod_s2 < PROD_W'(sum_q);
		price_s3 <= price_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			idx_q   <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (done) begin
				// group closed: drop it
				count_q <= '0;
				sum_q   <= '0;
				idx_q   <= '0;
			end else if (ctrl.wr) begin
				count_q <= count_q + CNT_W'(1);
				sum_q   <= sum_q + SUM_W'(wr_qty);
			end
		end
	end

	assign stat.full      = (count_q == CNT_W'(MAX_GROUP));
	assign stat.done      = done;
	assign stat.hit       = v_s3 && hit_s3;
	assign stat.hit_price = price_s3;

endmodule

/* hw/rtl/group_avg_threshold_price_sum.sv */
// Top level: per-part small-quantity revenue sum with finish/emit handshake.
// A closing row starts a walk that streams the buffered rows, one per cycle, through
//   the shared compare pipe; the input stalls during the walk.
// Rows are taken one per cycle between closes; a finish loads the output register
//   and waits while an earlier result is stalled.
// Reset (arst_n, asynchronous, active low) clears codes, sums, total and overflow, not the buffer.
module group_avg_threshold_price_sum #(
	parameter int MAX_GROUP = gats_pkg::MAX_GROUP_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             mode,
	input  logic [gats_pkg::CODE_W-1:0]      part_brand,
	input  logic [gats_pkg::CODE_W-1:0]      part_container,
	input  logic [gats_pkg::QTY_W-1:0]       quantity,
	input  logic [gats_pkg::PRICE_W-1:0]     price,
	input  logic                             last_in_group,
	// result channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [gats_pkg::TOTAL_W-1:0]     revenue_sum,
	output logic                             overflow,
	// configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [gats_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gats_pkg::CODE_W-1:0]      cfg_data
);

	gats_pkg::state_t   state_q, state_d;
	gats_pkg::gats_ctrl_t ctrl;
	gats_pkg::gats_stat_t stat;

	logic [gats_pkg::CODE_W-1:0]  brand_q;
	logic [gats_pkg::CODE_W-1:0]  container_q;
	logic [gats_pkg::TOTAL_W-1:0] total_q;
	logic                         ovf_q;
	logic                         out_valid_q;
	logic [gats_pkg::TOTAL_W-1:0] revenue_q;
	logic                         out_ovf_q;

	logic                         in_acc;
	logic                         row_acc;
	logic                         fin_acc;
	logic                         match;
	logic [gats_pkg::TOTAL_W:0]   total_add;

	// Stall everything during a walk; otherwise hold finish while a previous result
	// still waits on a stalled output, and let rows flow since they produce nothing.
	assign in_stall = (state_q != gats_pkg::ST_IDLE) ||
	                  ((gats_pkg::mode_t'(mode) == gats_pkg::MODE_FINISH) &&
	                   out_valid_q && out_stall);
	assign in_acc   = in_valid && !in_stall;
	assign row_acc  = in_acc && (gats_pkg::mode_t'(mode) == gats_pkg::MODE_ROW);
	assign fin_acc  = in_acc && (gats_pkg::mode_t'(mode) == gats_pkg::MODE_FINISH);
	assign match    = (part_brand == brand_q) && (part_container == container_q);

	// Sequencer: idle accepts transactions, walk runs the buffer through the compare pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gats_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctrl.wr   = 1'b0;
		ctrl.walk = 1'b0;
		unique case (state_q)
			gats_pkg::ST_IDLE: begin
				// buffer a matching row while space is left
				ctrl.wr = row_acc && match && !stat.full;
				if (row_acc && last_in_group) begin
					state_d = gats_pkg::ST_WALK;
				end
			end
			gats_pkg::ST_WALK: begin
				ctrl.walk = 1'b1;
				if (stat.done) begin
					state_d = gats_pkg::ST_IDLE;
				end
			end
			default: state_d = gats_pkg::ST_IDLE;
		endcase
	end

	gats_walk #(
		.MAX_GROUP(MAX_GROUP)
	) u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.wr_qty   (quantity),
		.wr_price (price),
		.stat     (stat)
	);

	// Configuration: always ready, unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brand_q     <= '0;
			container_q <= '0;
		end else if (cfg_valid) begin
			unique case (gats_pkg::cfg_idx_t'(cfg_index))
				gats_pkg::CFG_BRAND:     brand_q     <= cfg_data;
				gats_pkg::CFG_CONTAINER: container_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Saturating accumulate: total stays below 2^63 and price below 2^31,
	// so a carry into the top bit means the sum went past the maximum.
	assign total_add = {1'b0, total_q} + (gats_pkg::TOTAL_W + 1)'(stat.hit_price);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (row_acc && match && stat.full) begin
				// row beyond buffer depth: drop it, flag sticks until reset
				ovf_q <= 1'b1;
			end
			if (fin_acc) begin
				total_q <= '0;
			end else if (stat.hit) begin
				total_q <= total_add[gats_pkg::TOTAL_W] ? '1 :
				           total_add[gats_pkg::TOTAL_W-1:0];
			end
			if (fin_acc) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload register
	always_ff @(posedge clk) begin
		if (fin_acc) begin
			revenue_q <= total_q;
			out_ovf_q <= ovf_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign revenue_sum = revenue_q;
	assign overflow    = out_ovf_q;

endmodule

/* test/tb.sv */
// Self-checking testbench for the small-quantity revenue block.
`timescale 1ns / 100ps

module tb;

	localparam int          HALF_PERIOD   = 6;
	localparam int          RESET_CYCLES  = 7;
	localparam int          SETTLE_CYCLES = 100;  // outlasts the longest walk
	localparam int          WATCHDOG_MAX  = 3000;
	localparam int          HOLD_CYCLES   = 400;
	localparam int          PHASE_ITEMS   = 120;
	localparam int          OVF_ROWS      = gats_pkg::MAX_GROUP_DEF + 2;
	localparam longint      QTY_WEIGHT    = 5;
	localparam logic [gats_pkg::TOTAL_W-1:0] TOTAL_MAX = {gats_pkg::TOTAL_W{1'b1}};
	// indexes past the last register: writes there must be ignored
	localparam logic [gats_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [gats_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	typedef struct packed {
		gats_pkg::mode_t                op;
		logic [gats_pkg::CODE_W-1:0]    brand;
		logic [gats_pkg::CODE_W-1:0]    container;
		logic [gats_pkg::QTY_W-1:0]     qty;
		logic [gats_pkg::PRICE_W-1:0]   price;
		logic                           last;
	} lineitem_t;

	typedef struct packed {
		logic [gats_pkg::TOTAL_W-1:0]   sum;
		logic                           ovf;
	} emit_t;

	typedef enum {ROW_MATCH, ROW_NOISE, ROW_HALF, ROW_FINISH} row_kind_t;

	// Mirrors the group buffer, running total and sticky flag; holds the
	// totals that finish transactions still owe.
	class revenue_predictor;
		logic [gats_pkg::CODE_W-1:0]   want_brand;
		logic [gats_pkg::CODE_W-1:0]   want_container;
		logic [gats_pkg::QTY_W-1:0]    qty_q [gats_pkg::MAX_GROUP_DEF];
		logic [gats_pkg::PRICE_W-1:0]  price_q [gats_pkg::MAX_GROUP_DEF];
		longint unsigned               qty_sum;
		int unsigned                   count;
		logic [gats_pkg::TOTAL_W-1:0]  total;
		logic                          ovf;
		emit_t                         due_totals [$];
		int                            errors;

		function void clear();
			want_brand     = '0;
			want_container = '0;
			qty_sum        = 0;
			count          = 0;
			total          = '0;
			ovf            = 1'b0;
			errors         = 0;
			due_totals.delete();
		endfunction

		function void set_reg(logic [gats_pkg::CFG_IDX_W-1:0] idx,
				      logic [gats_pkg::CODE_W-1:0] data);
			if (idx == gats_pkg::CFG_BRAND)
				want_brand = data;
			else if (idx == gats_pkg::CFG_CONTAINER)
				want_container = data;
		endfunction

		function void note_row(lineitem_t r);
			longint unsigned lhs;
			emit_t           e;
			if (r.op == gats_pkg::MODE_FINISH) begin
				e.sum = total;
				e.ovf = ovf;
				due_totals.insert(due_totals.size(), e);
				total = '0;
				return;
			end
			if (r.brand == want_brand && r.container == want_container) begin
				if (count < gats_pkg::MAX_GROUP_DEF) begin
					qty_q[count]   = r.qty;
					price_q[count] = r.price;
					qty_sum        += r.qty;
					count++;
				end else begin
					ovf = 1'b1;
				end
			end
			if (r.last) begin
				for (int i = 0; i < count; i++) begin
					lhs = longint'(qty_q[i]) * QTY_WEIGHT * longint'(count);
					if (lhs < qty_sum) begin
						if (total > TOTAL_MAX - gats_pkg::TOTAL_W'(price_q[i]))
							total = TOTAL_MAX;
						else
							total = total + gats_pkg::TOTAL_W'(price_q[i]);
					end
				end
				qty_sum = 0;
				count   = 0;
			end
		endfunction

		task report_mismatch(string what);
			$display("%0t: %s", $time, what);
			errors++;
		endtask

		task check_emit(logic [gats_pkg::TOTAL_W-1:0] sum, logic ovf_bit);
			emit_t want;
			if (due_totals.size() == 0) begin
				report_mismatch($sformatf("result with nothing due: revenue_sum %0d", sum));
			end else begin
				want = due_totals.pop_front();
				if (sum !== want.sum)
					report_mismatch($sformatf("revenue_sum %0d, want %0d", sum, want.sum));
				if (ovf_bit !== want.ovf)
					report_mismatch($sformatf("overflow %0b, want %0b", ovf_bit, want.ovf));
			end
		endtask
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_stall;
	logic                            mode;
	logic [gats_pkg::CODE_W-1:0]     part_brand;
	logic [gats_pkg::CODE_W-1:0]     part_container;
	logic [gats_pkg::QTY_W-1:0]      quantity;
	logic [gats_pkg::PRICE_W-1:0]    price;
	logic                            last_in_group;
	logic                            out_valid;
	logic                            out_stall;
	logic [gats_pkg::TOTAL_W-1:0]    revenue_sum;
	logic                            overflow;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [gats_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [gats_pkg::CODE_W-1:0]     cfg_data;

	revenue_predictor                sb;
	logic [gats_pkg::CODE_W-1:0]     cur_brand;
	logic [gats_pkg::CODE_W-1:0]     cur_container;
	bit                              calm;       // no idling on either side while set
	bit                              hold_req;   // ask the receiver for one long hold-off
	int                              hold_left;
	int                              stall_left;
	int                              quiet_cycles;
	int                              items_sent;

	group_avg_threshold_price_sum u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.part_brand     (part_brand),
		.part_container (part_container),
		.quantity       (quantity),
		.price          (price),
		.last_in_group  (last_in_group),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.revenue_sum    (revenue_sum),
		.overflow       (overflow),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// Result side: check every accepted transaction against the oldest due
	// total, then decide the stall for the next cycle. A long hold-off is
	// counted here so that the sender keeps offering meanwhile.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_emit(revenue_sum, overflow);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				// start a stall burst, this cycle included, with stall_left holding the rest
				stall_left = $urandom_range(0, 15);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: end the run when no transaction moves on any channel for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_MAX) begin
			$display("group_avg_threshold_price_sum: mismatch");
			$finish;
		end
	end

	function automatic lineitem_t row(gats_pkg::mode_t op, logic [gats_pkg::CODE_W-1:0] b,
					  logic [gats_pkg::CODE_W-1:0] c,
					  logic [gats_pkg::QTY_W-1:0] q,
					  logic [gats_pkg::PRICE_W-1:0] p, logic l);
		lineitem_t r;
		r.op        = op;
		r.brand     = b;
		r.container = c;
		r.qty       = q;
		r.price     = p;
		r.last      = l;
		return r;
	endfunction

	// Build a random row of the given kind against the codes now programmed.
	function automatic lineitem_t make_row(row_kind_t kind, logic l);
		lineitem_t r;
		r.op        = (kind == ROW_FINISH) ? gats_pkg::MODE_FINISH : gats_pkg::MODE_ROW;
		r.brand     = gats_pkg::CODE_W'($urandom);
		r.container = gats_pkg::CODE_W'($urandom);
		r.last      = l;
		case (kind)
			ROW_MATCH: begin
				r.brand     = cur_brand;
				r.container = cur_container;
			end
			ROW_HALF: begin
				if ($urandom_range(0, 1)) begin
					r.brand     = cur_brand;
					r.container = ~cur_container;
				end else begin
					r.brand     = ~cur_brand;
					r.container = cur_container;
				end
			end
			default: ;
		endcase
		// small quantities are the ones that fall under a fifth of the mean
		case ($urandom_range(0, 9))
			0:       r.qty = '0;
			1:       r.qty = '1;
			2, 3, 4: r.qty = gats_pkg::QTY_W'($urandom_range(1, 40));
			default: r.qty = gats_pkg::QTY_W'($urandom_range(0, 32767));
		endcase
		case ($urandom_range(0, 9))
			0:       r.price = '0;
			1:       r.price = '1;
			default: r.price = gats_pkg::PRICE_W'($urandom);
		endcase
		return r;
	endfunction

	// Offer one transaction, possibly after an idle burst, and hold it until taken.
	task send_item(lineitem_t r);
		if (!calm && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid       <= 1'b1;
		mode           <= r.op;
		part_brand     <= r.brand;
		part_container <= r.container;
		quantity       <= r.qty;
		price          <= r.price;
		last_in_group  <= r.last;
		do @(posedge clk); while (in_stall);
		sb.note_row(r);
		items_sent++;
	endtask

	// Leave cfg_valid high on return; the caller drops it after the last write.
	task write_reg(logic [gats_pkg::CFG_IDX_W-1:0] idx, logic [gats_pkg::CODE_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, data);
	endtask

	task program_codes(logic [gats_pkg::CODE_W-1:0] b, logic [gats_pkg::CODE_W-1:0] c);
		write_reg(gats_pkg::CFG_BRAND, b);
		write_reg(gats_pkg::CFG_CONTAINER, c);
		write_reg(CFG_SPARE_LO, gats_pkg::CODE_W'($urandom));
		write_reg(CFG_SPARE_HI, gats_pkg::CODE_W'($urandom));
		cfg_valid     <= 1'b0;
		cur_brand     = b;
		cur_container = c;
	endtask

	// Drain: wait for every due total, then let a closing walk run out.
	task settle();
		in_valid <= 1'b0;
		while (sb.due_totals.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One part's group: mostly matching rows, some noise, rare stray finishes.
	task send_group(int len);
		int        pick;
		row_kind_t kind;
		for (int k = 0; k < len; k++) begin
			pick = $urandom_range(0, 19);
			if (pick == 0)
				kind = ROW_FINISH;
			else if (pick <= 2)
				kind = ROW_NOISE;
			else if (pick == 3)
				kind = ROW_HALF;
			else
				kind = ROW_MATCH;
			send_item(make_row(kind, k == len - 1));
		end
	endtask

	task run_traffic(int n);
		int start;
		int pick;
		start = items_sent;
		while (items_sent - start < n) begin
			pick = $urandom_range(0, 19);
			if (pick == 0)
				send_group($urandom_range(60, 70));
			else if (pick <= 3)
				send_group($urandom_range(11, 40));
			else
				send_group($urandom_range(1, 10));
			if ($urandom_range(0, 2) == 0)
				send_item(make_row(ROW_FINISH, 1'($urandom_range(0, 1))));
		end
		send_item(make_row(ROW_FINISH, 1'b0));
	endtask

	initial begin
		sb = new;
		sb.clear();
		cur_brand      = '0;
		cur_container  = '0;
		calm           = 1'b0;
		hold_req       = 1'b0;
		hold_left      = 0;
		stall_left     = 0;
		quiet_cycles   = 0;
		items_sent     = 0;
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		mode           <= gats_pkg::MODE_ROW;
		part_brand     <= '0;
		part_container <= '0;
		quantity       <= '0;
		price          <= '0;
		last_in_group  <= 1'b0;
		out_stall      <= 1'b0;
		cfg_valid      <= 1'b0;
		cfg_index      <= gats_pkg::CFG_BRAND;
		cfg_data       <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part under the reset codes (brand 0, container 0).
		// Extremes of quantity and price; two small rows qualify.
		send_item(row(gats_pkg::MODE_ROW, 8'h00, 8'h00, '0, '0, 1'b0));
		send_item(row(gats_pkg::MODE_ROW, 8'h00, 8'h00, '1, '1, 1'b0));
		send_item(row(gats_pkg::MODE_ROW, 8'h00, 8'h00, 15'd1, '1, 1'b0));
		send_item(row(gats_pkg::MODE_ROW, 8'h00, 8'h00, '1, 31'h2AAAAAAA, 1'b0));
		// one code matches, the other does not: not buffered
		send_item(row(gats_pkg::MODE_ROW, 8'h00, 8'hFF, 15'd3, 31'd5, 1'b0));
		send_item(row(gats_pkg::MODE_ROW, 8'hFF, 8'h00, 15'd3, 31'd5, 1'b0));
		// non-matching row still closes the group
		send_item(row(gats_pkg::MODE_ROW, 8'hFF, 8'hFF, '0, '1, 1'b1));
		// close with nothing buffered
		send_item(row(gats_pkg::MODE_ROW, 8'hFF, 8'hFF, 15'd7, 31'd7, 1'b1));
		// finish ignores all of its other fields
		send_item(row(gats_pkg::MODE_FINISH, 8'hFF, 8'hFF, '1, '1, 1'b1));
		send_item(row(gats_pkg::MODE_FINISH, 8'h00, 8'h00, '0, '0, 1'b0));
		// finish in the middle of a group leaves the group open
		send_item(row(gats_pkg::MODE_ROW, 8'h00, 8'h00, 15'd100, 31'd1000, 1'b0));
		send_item(row(gats_pkg::MODE_FINISH, 8'h00, 8'h00, '0, '0, 1'b0));
		send_item(row(gats_pkg::MODE_ROW, 8'h00, 8'h00, 15'd1, 31'd123, 1'b0));
		send_item(row(gats_pkg::MODE_ROW, 8'h00, 8'h00, 15'd100, 31'd456, 1'b1));
		send_item(row(gats_pkg::MODE_FINISH, 8'h00, 8'h00, '0, '0, 1'b0));
		// lone zero-quantity row: 0 < 0 fails
		send_item(row(gats_pkg::MODE_ROW, 8'h00, 8'h00, '0, 31'd999, 1'b1));
		send_item(row(gats_pkg::MODE_FINISH, 8'h00, 8'h00, '0, '0, 1'b0));
		// product equal to the sum does not qualify
		send_item(row(gats_pkg::MODE_ROW, 8'h00, 8'h00, 15'd1, 31'd11, 1'b0));
		send_item(row(gats_pkg::MODE_ROW, 8'h00, 8'h00, 15'd9, 31'd22, 1'b1));
		send_item(row(gats_pkg::MODE_FINISH, 8'h00, 8'h00, '0, '0, 1'b0));

		// Group larger than the buffer: the extra rows drop, the flag sticks.
		for (int k = 0; k < OVF_ROWS; k++)
			send_item(make_row(ROW_MATCH, k == OVF_ROWS - 1));
		send_item(make_row(ROW_FINISH, 1'b0));
		send_item(make_row(ROW_MATCH, 1'b1));
		send_item(make_row(ROW_FINISH, 1'b0));
		settle();

		// Extreme codes; open with a long receiver hold-off while rows and
		// finishes keep coming, so the output backs up into the input.
		program_codes(8'hFF, 8'hFF);
		hold_req = 1'b1;
		repeat (4) begin
			send_group(3);
			send_item(make_row(ROW_FINISH, 1'b0));
		end
		run_traffic(PHASE_ITEMS);
		settle();

		// Random codes, no idling on either side.
		calm = 1'b1;
		program_codes(gats_pkg::CODE_W'($urandom), gats_pkg::CODE_W'($urandom));
		run_traffic(PHASE_ITEMS);
		settle();
		calm = 1'b0;

		program_codes(8'h00, 8'hFF);
		run_traffic(PHASE_ITEMS);
		settle();

		program_codes(8'hFF, 8'h00);
		run_traffic(PHASE_ITEMS);
		settle();

		// Last part runs flat out.
		calm = 1'b1;
		program_codes(gats_pkg::CODE_W'($urandom), gats_pkg::CODE_W'($urandom));
		run_traffic(PHASE_ITEMS);
		settle();

		if (sb.errors == 0)
			$display("group_avg_threshold_price_sum: match");
		else
			$display("group_avg_threshold_price_sum: mismatch");
		$finish;
	end

endmodule
